// ===== hw/rtl/ufs_pkg.sv =====
// Shared types and constants for the UART frame serializer.
`timescale 1ns / 1ps
`default_nettype none
package ufs_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitTimeW = 16;
  localparam int unsigned DurW     = 17;
  localparam int unsigned NBitsW   = 4;
  localparam int unsigned SegW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = 1;
  localparam int unsigned FifoCntW  = 2;
  localparam logic [SegW-1:0] MaxSeg = 4'd10;

  localparam logic [BitTimeW-1:0] BitTimeRst = 16'd104;
  localparam logic [NBitsW-1:0]   DataBitsRst = 4'd0;
  localparam logic [NBitsW-1:0]   FullBits    = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIT_TIME    = 2'd0,
    CFG_DATA_BITS   = 2'd1,
    CFG_PARITY_MODE = 2'd2,
    CFG_STOP_MODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PAR_NONE   = 2'd0,
    PAR_ODD    = 2'd1,
    PAR_EVEN   = 2'd2,
    PAR_UNUSED = 2'd3
  } parity_e;

  typedef enum logic [1:0] {
    STOP_HALF     = 2'd0,
    STOP_ONE      = 2'd1,
    STOP_ONE_HALF = 2'd2,
    STOP_TWO      = 2'd3
  } stop_e;

  typedef struct packed {
    logic [ByteW-1:0]    tx_byte;
    logic [NBitsW-1:0]   nbits;
    logic                has_par;
    logic                par_bit;
    logic [BitTimeW-1:0] bit_time;
    logic [DurW-1:0]     stop_len;
  } job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/uart_frame_serializer.sv =====
// Top level of the UART frame serializer.
//
//   channel | signals                                     | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, tx_byte_i           | sink
//   out     | out_valid_o, out_stall_i, line_level_o,     | source
//           | duration_o, last_segment_o                  |
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,      | sink
//           | cfg_data_i                                  |
//
// One segment beat per cycle from the back-end sequencer while out_stall_i is
// low: a frame has 3 to 11 segments (start + data bits + parity + stop).
// A byte goes through the frame queue and job register to the registered beat.
// The two-entry frame queue takes bytes while the back end is stalled.
// Reset restores bit_time 104, eight data bits, no parity, one stop bit.
`timescale 1ns / 1ps
`default_nettype none
module uart_frame_serializer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ufs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ufs_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ufs_pkg::ByteW-1:0]    tx_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              line_level_o,
  output logic [ufs_pkg::DurW-1:0]          duration_o,
  output logic                              last_segment_o
);
  import ufs_pkg::*;

  job_t front_job;
  job_t queue_job;
  logic q_full, q_valid, q_pop, q_push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign q_push      = in_valid_i && !q_full;

  ufs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tx_byte_i   (tx_byte_i),
    .job_o       (front_job)
  );

  ufs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_job),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (queue_job)
  );

  ufs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (queue_job),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_level_o   (line_level_o),
    .duration_o     (duration_o),
    .last_segment_o (last_segment_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/ufs_front.sv =====
// Front end: configuration registers and per-byte frame classification.
`timescale 1ns / 1ps
`default_nettype none
module ufs_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [ufs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ufs_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic [ufs_pkg::ByteW-1:0]    tx_byte_i,
  output ufs_pkg::job_t                     job_o
);
  import ufs_pkg::*;

  logic [BitTimeW-1:0] bit_time_q;
  logic [NBitsW-1:0]   data_bits_q;
  parity_e             parity_q;
  stop_e               stop_q;
  logic [NBitsW-1:0]   nbits;
  logic [ByteW-1:0]    sent;
  logic [DurW-1:0]     bt_ext;
  logic [DurW-1:0]     stop_len;
  logic                ones_odd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_time_q  <= BitTimeRst;
      data_bits_q <= DataBitsRst;
      parity_q    <= PAR_NONE;
      stop_q      <= STOP_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BIT_TIME:    bit_time_q  <= cfg_data_i[BitTimeW-1:0];
        CFG_DATA_BITS:   data_bits_q <= cfg_data_i[NBitsW-1:0];
        CFG_PARITY_MODE: parity_q    <= parity_e'(cfg_data_i[1:0]);
        CFG_STOP_MODE:   stop_q      <= stop_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    nbits = data_bits_q;
    if (data_bits_q == '0 || data_bits_q > FullBits) begin
      nbits = FullBits;
    end
    for (int i = 0; i < ByteW; i++) begin
      sent[i] = tx_byte_i[i] & (NBitsW'(i) < nbits);
    end
    ones_odd = ^sent;
    bt_ext   = {1'b0, bit_time_q};
    case (stop_q)
      STOP_HALF:     stop_len = bt_ext >> 1;
      STOP_ONE_HALF: stop_len = bt_ext + (bt_ext >> 1);
      STOP_TWO:      stop_len = bt_ext << 1;
      default:       stop_len = bt_ext;
    endcase
    job_o.tx_byte  = tx_byte_i;
    job_o.nbits    = nbits;
    job_o.has_par  = (parity_q != PAR_NONE);
    job_o.par_bit  = (parity_q == PAR_ODD) ? ~ones_odd : ones_odd;
    job_o.bit_time = bit_time_q;
    job_o.stop_len = stop_len;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ufs_fifo.sv =====
// Two-entry frame queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module ufs_fifo (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire ufs_pkg::job_t push_data_i,
  output logic       full_o,
  output logic       valid_o,
  input  wire logic  pop_i,
  output ufs_pkg::job_t pop_data_o
);
  import ufs_pkg::*;

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + FifoCntW'(push_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== hw/rtl/ufs_back.sv =====
// Back end: segment sequencer with registered output beat.
`timescale 1ns / 1ps
`default_nettype none
module ufs_back (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  input  wire ufs_pkg::job_t job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic       line_level_o,
  output logic [ufs_pkg::DurW-1:0] duration_o,
  output logic       last_segment_o
);
  import ufs_pkg::*;

  job_t            job_q;
  logic            busy_q;
  logic [SegW-1:0] seg_q;
  logic            valid_q;
  logic            level_q;
  logic [DurW-1:0] dur_q;
  logic            last_q;

  logic            adv;
  logic            seg_level;
  logic [DurW-1:0] seg_dur;
  logic            seg_last;
  logic [SegW-1:0] bit_idx;

  assign adv   = busy_q && (!valid_q || !out_stall_i);
  assign pop_o = job_valid_i && (!busy_q || (adv && seg_last));

  always_comb begin
    bit_idx   = seg_q - 1'b1;
    seg_level = 1'b1;
    seg_dur   = {1'b0, job_q.bit_time};
    seg_last  = 1'b0;
    if (seg_q == '0) begin
      seg_level = 1'b0;
    end else if (seg_q <= job_q.nbits) begin
      seg_level = job_q.tx_byte[bit_idx[2:0]];
    end else if (job_q.has_par && seg_q == job_q.nbits + 1'b1) begin
      seg_level = job_q.par_bit;
    end else begin
      seg_dur  = job_q.stop_len;
      seg_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      seg_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (adv) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        seg_q  <= '0;
      end else if (adv) begin
        seg_q <= seg_q + 1'b1;
        if (seg_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      level_q <= seg_level;
      dur_q   <= seg_dur;
      last_q  <= seg_last;
    end
  end

  assign out_valid_o    = valid_q;
  assign line_level_o   = level_q;
  assign duration_o     = dur_q;
  assign last_segment_o = last_q;

  a_stop_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q |-> level_q)
    else $error("stop segment not high");
  a_seg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> seg_q <= MaxSeg)
    else $error("segment index out of range");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && seg_last && !pop_o |=> !busy_q)
    else $error("sequencer still busy after stop");
  a_start_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && seg_q == '0 |=> !level_q && !last_q)
    else $error("start segment malformed");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the UART frame serializer: directed and random frames.
`timescale 1ns / 1ps
module tb_top;
  import ufs_pkg::*;

  localparam int unsigned StallLimit = 500;
  localparam int unsigned TotalBytes = 410;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] dur;
    logic            last;
  } segment_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_BIT_TIME;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    tx_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                line_level_o;
  logic [DurW-1:0]     duration_o;
  logic                last_segment_o;

  logic [BitTimeW-1:0] cur_bit_time = BitTimeRst;
  logic [NBitsW-1:0]   cur_data_bits = DataBitsRst;
  parity_e             cur_parity = PAR_NONE;
  stop_e               cur_stop = STOP_ONE;

  segment_t    pending_segments[$];
  bit          idle_on = 1'b1;
  int unsigned n_errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_segments = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  uart_frame_serializer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tx_byte_i     (tx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_level_o  (line_level_o),
    .duration_o    (duration_o),
    .last_segment_o(last_segment_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_frame(logic [ByteW-1:0] data);
    int unsigned     nbits;
    logic            ones;
    logic [DurW-1:0] bt;
    logic [DurW-1:0] stop_len;
    nbits = cur_data_bits;
    if (nbits == 0 || nbits > ByteW) nbits = ByteW;
    bt = {1'b0, cur_bit_time};
    ones = 1'b0;
    pending_segments.push_back('{level: 1'b0, dur: bt, last: 1'b0});
    for (int i = 0; i < nbits; i++) begin
      ones ^= data[i];
      pending_segments.push_back('{level: data[i], dur: bt, last: 1'b0});
    end
    if (cur_parity != PAR_NONE) begin
      pending_segments.push_back('{level: (cur_parity == PAR_ODD) ? ~ones : ones,
                                   dur: bt, last: 1'b0});
    end
    case (cur_stop)
      STOP_HALF:     stop_len = bt >> 1;
      STOP_ONE_HALF: stop_len = bt + (bt >> 1);
      STOP_TWO:      stop_len = bt << 1;
      default:       stop_len = bt;
    endcase
    pending_segments.push_back('{level: 1'b1, dur: stop_len, last: 1'b1});
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on segment %0d: %s got 0x%0h, want 0x%0h",
             $time, n_segments, what, got, want);
    n_errors++;
  endtask

  // Hold valid across back-to-back bytes; drop it only for an idle burst.
  task automatic send_byte(logic [ByteW-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tx_byte_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(data);
    n_bytes++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_segments.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BIT_TIME:    cur_bit_time = value;
      CFG_DATA_BITS:   cur_data_bits = value[NBitsW-1:0];
      CFG_PARITY_MODE: cur_parity = parity_e'(value[1:0]);
      CFG_STOP_MODE:   cur_stop = stop_e'(value[1:0]);
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  // Upper data bits of the narrow registers carry junk that must be ignored.
  task automatic set_config(logic [BitTimeW-1:0] bt, logic [NBitsW-1:0] db, parity_e pm,
                            stop_e sm);
    logic [CfgDataW-1:0] junk;
    wait_idle();
    junk = $urandom;
    write_reg(CFG_BIT_TIME, bt);
    write_reg(CFG_DATA_BITS, {junk[15:4], db});
    write_reg(CFG_PARITY_MODE, {junk[13:0], 2'(pm)});
    write_reg(CFG_STOP_MODE, {junk[15:2], 2'(sm)});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
  endtask

  task automatic test_parity_modes();
    parity_e modes[4] = '{PAR_NONE, PAR_ODD, PAR_EVEN, PAR_UNUSED};
    foreach (modes[m]) begin
      set_config(16'd7, 4'd8, modes[m], STOP_ONE);
      send_byte(8'h00);
      send_byte(8'hB7);
    end
  endtask

  task automatic test_stop_lengths();
    stop_e modes[4] = '{STOP_HALF, STOP_ONE, STOP_ONE_HALF, STOP_TWO};
    foreach (modes[m]) begin
      set_config(16'hFFFF, 4'd0, PAR_EVEN, modes[m]);
      send_byte(8'h55);
    end
    set_config(16'd1, 4'd8, PAR_ODD, STOP_HALF);
    send_byte(8'hAA);
  endtask

  task automatic test_data_counts();
    set_config(16'd3, 4'd1, PAR_ODD, STOP_ONE_HALF);
    send_byte(8'h01);
    set_config(16'd3, 4'd9, PAR_NONE, STOP_TWO);
    send_byte(8'h80);
    set_config(16'd3, 4'd15, PAR_EVEN, STOP_HALF);
    send_byte(8'hFE);
  endtask

  task automatic test_zero_bit_time();
    set_config(16'd0, 4'd5, PAR_UNUSED, STOP_TWO);
    send_byte(8'h3C);
  endtask

  task automatic test_random_frames();
    logic [BitTimeW-1:0] bt;
    int unsigned         burst;
    while (n_bytes < TotalBytes) begin
      case ($urandom_range(0, 9))
        0:       bt = 16'd1;
        1:       bt = 16'hFFFF;
        2:       bt = 16'd0;
        3:       bt = 16'($urandom_range(2, 15));
        default: bt = 16'($urandom);
      endcase
      set_config(bt, 4'($urandom_range(0, 15)), parity_e'($urandom_range(0, 3)),
                 stop_e'($urandom_range(0, 3)));
      idle_on = (TotalBytes - n_bytes > 40) && ($urandom_range(0, 3) != 0);
      burst = $urandom_range(15, 40);
      for (int i = 0; i < burst && n_bytes < TotalBytes; i++) begin
        case ($urandom_range(0, 9))
          0:       send_byte(8'h00);
          1:       send_byte(8'hFF);
          default: send_byte(8'($urandom));
        endcase
      end
    end
  endtask

  // Back-pressure on the segment output in random bursts.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    segment_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_segments.size() == 0) begin
        report_mismatch("unexpected beat, line_level", line_level_o, 0);
      end else begin
        want = pending_segments.pop_front();
        if (line_level_o !== want.level) report_mismatch("line_level", line_level_o, want.level);
        if (duration_o !== want.dur) report_mismatch("duration", duration_o, want.dur);
        if (last_segment_o !== want.last) begin
          report_mismatch("last_segment", last_segment_o, want.last);
        end
      end
      n_segments++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: %0d segments still pending", pending_segments.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_parity_modes();
    test_stop_lengths();
    test_data_counts();
    test_zero_bit_time();
    test_random_frames();
    wait_idle();
    repeat (12) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d segments, %0d register writes.",
             n_bytes, n_segments, n_cfg_writes);
    $display("Covered all parity and stop modes, data counts 1 to 15 and bit times 0 to 65535.");
    if (n_errors == 0 && pending_segments.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ufs_pkg.sv
hw/rtl/ufs_front.sv
hw/rtl/ufs_fifo.sv
hw/rtl/ufs_back.sv
hw/rtl/uart_frame_serializer.sv
tb/tb_top.sv
